FILE: rtl/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared widths for the polygon area and perimeter core and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pap_pkg;

  // Result field widths
  localparam int AREA_W  = 40;
  localparam int PERIM_W = 36;

  // Accumulator widths
  localparam int CROSS_W = 48;
  localparam int LSUM_W  = 40;

endpackage

`default_nettype wire

FILE: rtl/pap_vertex_if.sv
// ----------------------------------------------------------------------------
// pap_vertex_if
// Vertex channel: one polygon vertex per transaction, last one marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface pap_vertex_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/pap_result_if.sv
// ----------------------------------------------------------------------------
// pap_result_if
// Result channel: twice the area and the perimeter of one closed polygon.
// ----------------------------------------------------------------------------
`default_nettype none

interface pap_result_if;
  import pap_pkg::*;

  logic               valid;
  logic               ready;
  logic [AREA_W-1:0]  twice_area;
  logic [PERIM_W-1:0] perimeter;

  modport source (output valid, output twice_area, output perimeter, input ready);
  modport sink   (input valid, input twice_area, input perimeter, output ready);
endinterface

`default_nettype wire

FILE: rtl/polygon_area_perimeter_core.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_core
// Shoelace area and perimeter of a streamed closed polygon.
// ----------------------------------------------------------------------------
// Vertices arrive one per transaction on vtx; the vertex with last_vertex set
// closes the polygon, and one transaction on res then carries twice the
// absolute area (saturated to 40 bits) and the perimeter (edge lengths
// truncated to FRAC_BITS fractional bits, summed and saturated to 36 bits).
// The first vertex of a polygon leaves vtx.ready high unless it is marked.
// Every further vertex adds one edge and keeps vtx.ready low until that edge
// is summed; the marked vertex adds the closing edge as well, and the core
// then holds until the result register is free to load. Most of the busy
// time goes to the bit-serial square root, which retires one bit of edge
// length per cycle on a single subtract-compare unit; the products and
// squares go one after another through a single multiplier. A single marked
// vertex gives zero area and zero perimeter; two vertices count the one edge
// both ways. The result register lets the next polygon start while a result
// is still waiting on res.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_perimeter_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  pap_vertex_if.sink    vtx,
  pap_result_if.source  res
);
  import pap_pkg::*;

  // Derived widths
  localparam int CW     = COORD_BITS;
  localparam int MW     = CW + 2;               // multiplier operand
  localparam int PW     = 2 * MW;               // product
  localparam int DW     = PW + 1;               // cross product difference
  localparam int AW     = ((DW > CROSS_W) ? DW : CROSS_W) + 1;
  localparam int SQ_W   = 2 * CW + 2;           // dx^2 + dy^2
  localparam int LEN_W  = CW + FRAC_BITS + 1;   // edge length
  localparam int REM_W  = LEN_W + 2;
  localparam int RAD_W  = 2 * LEN_W;
  localparam int SUM_W  = ((LEN_W > LSUM_W) ? LEN_W : LSUM_W) + 1;
  localparam int ITER_W = $clog2(LEN_W);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_MUL0 = 4'd2;
  localparam logic [3:0] ST_MUL1 = 4'd3;
  localparam logic [3:0] ST_MUL2 = 4'd4;
  localparam logic [3:0] ST_MUL3 = 4'd5;
  localparam logic [3:0] ST_RAD  = 4'd6;
  localparam logic [3:0] ST_ROOT = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [3:0] state;

  // Polygon state
  logic                 started;
  logic                 last_q;
  logic                 closing;
  logic signed [CW-1:0] first_x, first_y;
  logic signed [CW-1:0] previous_x, previous_y;
  logic signed [CROSS_W-1:0] cross_sum;
  logic [LSUM_W-1:0]         length_sum;

  // Edge operands: from (ax, ay) to (bx, by)
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [CW:0]          ux, uy;

  // Shared multiplier and its working registers
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] hold;
  logic signed [DW-1:0] cdiff;

  // Square root working registers
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [LEN_W-1:0]  root;
  logic [ITER_W-1:0] iter;

  // Result register
  logic               res_valid;
  logic [AREA_W-1:0]  area_q;
  logic [PERIM_W-1:0] perim_q;

  // Edge differences
  logic signed [CW:0] dx, dy;
  assign dx = (CW+1)'(bx) - (CW+1)'(ax);
  assign dy = (CW+1)'(by) - (CW+1)'(ay);

  // Multiplier operand select
  always_comb begin
    unique case (state)
      ST_MUL0: begin
        mul_a = MW'(ax);
        mul_b = MW'(by);
      end
      ST_MUL1: begin
        mul_a = MW'(ay);
        mul_b = MW'(bx);
      end
      ST_MUL2: begin
        mul_a = signed'(MW'(ux));
        mul_b = signed'(MW'(ux));
      end
      ST_MUL3: begin
        mul_a = signed'(MW'(uy));
        mul_b = signed'(MW'(uy));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating cross sum
  logic signed [AW-1:0]      cross_wide;
  logic signed [CROSS_W-1:0] cross_next;
  assign cross_wide = AW'(cross_sum) + AW'(cdiff);
  always_comb begin
    if (cross_wide[AW-1:CROSS_W-1] == '0 || cross_wide[AW-1:CROSS_W-1] == '1) begin
      cross_next = cross_wide[CROSS_W-1:0];
    end else if (cross_wide[AW-1]) begin
      cross_next = {1'b1, {(CROSS_W-1){1'b0}}};
    end else begin
      cross_next = {1'b0, {(CROSS_W-1){1'b1}}};
    end
  end

  // Radicand: squares summed, scaled by 4^FRAC_BITS
  logic [PW-1:0]    sq_sum;
  logic [RAD_W-1:0] rad_init;
  assign sq_sum   = unsigned'(hold) + unsigned'(prod);
  assign rad_init = RAD_W'(sq_sum[SQ_W-1:0]) << (2 * FRAC_BITS);

  // One root digit per cycle
  logic [REM_W-1:0] rem_sh, trial;
  logic             take;
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign take   = (rem_sh >= trial);

  // Saturating length sum
  logic [SUM_W-1:0]  length_wide;
  logic [LSUM_W-1:0] length_next;
  assign length_wide = SUM_W'(length_sum) + SUM_W'(root);
  assign length_next = (length_wide[SUM_W-1:LSUM_W] != '0) ? '1
                                                          : length_wide[LSUM_W-1:0];

  // Result formatting
  logic [CROSS_W-1:0] area_abs;
  logic [AREA_W-1:0]  area_sat;
  logic [PERIM_W-1:0] perim_sat;
  assign area_abs  = cross_sum[CROSS_W-1] ? unsigned'(-cross_sum) : unsigned'(cross_sum);
  assign area_sat  = (area_abs[CROSS_W-1:AREA_W] != '0) ? '1 : area_abs[AREA_W-1:0];
  assign perim_sat = (length_sum[LSUM_W-1:PERIM_W] != '0) ? '1
                                                          : length_sum[PERIM_W-1:0];

  logic in_fire;
  logic res_free;
  logic res_load;
  assign vtx.ready  = (state == ST_IDLE);
  assign in_fire    = vtx.valid && vtx.ready;
  assign res_free   = !res_valid || res.ready;
  assign res_load   = (state == ST_FIN) && res_free;

  assign res.valid      = res_valid;
  assign res.twice_area = area_q;
  assign res.perimeter  = perim_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Load a finished result, else drop the held one once taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            previous_x <= vtx.vertex_x;
            previous_y <= vtx.vertex_y;
            last_q     <= vtx.last_vertex;
            bx         <= vtx.vertex_x;
            by         <= vtx.vertex_y;
            if (started) begin
              // Edge from the previous vertex to this one
              ax      <= previous_x;
              ay      <= previous_y;
              closing <= 1'b0;
              state   <= ST_DIFF;
            end else begin
              first_x    <= vtx.vertex_x;
              first_y    <= vtx.vertex_y;
              cross_sum  <= '0;
              length_sum <= '0;
              started    <= 1'b1;
              if (vtx.last_vertex) begin
                // Lone vertex: closing edge of zero length
                ax      <= vtx.vertex_x;
                ay      <= vtx.vertex_y;
                closing <= 1'b1;
                state   <= ST_DIFF;
              end
            end
          end
        end
        ST_DIFF: begin
          ux    <= dx[CW] ? unsigned'(-dx) : unsigned'(dx);
          uy    <= dy[CW] ? unsigned'(-dy) : unsigned'(dy);
          state <= ST_MUL0;
        end
        ST_MUL0: begin
          prod  <= mul_a * mul_b;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          hold  <= prod;
          prod  <= mul_a * mul_b;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          cdiff <= DW'(hold) - DW'(prod);
          prod  <= mul_a * mul_b;
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          cross_sum <= cross_next;
          hold      <= prod;
          prod      <= mul_a * mul_b;
          state     <= ST_RAD;
        end
        ST_RAD: begin
          rad   <= rad_init;
          rem   <= '0;
          root  <= '0;
          iter  <= ITER_W'(LEN_W - 1);
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          rad  <= rad << 2;
          rem  <= take ? (rem_sh - trial) : rem_sh;
          root <= {root[LEN_W-2:0], take};
          iter <= iter - 1'b1;
          if (iter == '0) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          length_sum <= length_next;
          if (closing) begin
            state <= ST_FIN;
          end else if (last_q) begin
            // Closing edge: last vertex back to the first
            ax      <= bx;
            ay      <= by;
            bx      <= first_x;
            by      <= first_y;
            closing <= 1'b1;
            state   <= ST_DIFF;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_FIN: begin
          // Hold until the result register is free
          if (res_free) begin
            area_q     <= area_sat;
            perim_q    <= perim_sat;
            cross_sum  <= '0;
            length_sum <= '0;
            started    <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pap_checker.sv
// ----------------------------------------------------------------------------
// pap_checker
// Port-level checks for the polygon area and perimeter core.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  last_vertex,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [pap_pkg::AREA_W-1:0]  twice_area,
  input  logic [pap_pkg::PERIM_W-1:0] perimeter
);
  import pap_pkg::*;

  // A stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(twice_area) && $stable(perimeter))
    else $error("result changed while stalled");

  // A closing vertex always keeps the core busy for its closing edge
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_vertex |=> !in_ready)
    else $error("core ready right after a closing vertex");

  // A result is loaded only at the end of busy work
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the core was idle");

  // Reset leaves the core idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("core not idle after reset");

endmodule

bind polygon_area_perimeter_core pap_checker u_pap_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (vtx.valid),
  .in_ready    (vtx.ready),
  .last_vertex (vtx.last_vertex),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .twice_area  (res.twice_area),
  .perimeter   (res.perimeter)
);

`default_nettype wire
